// File: hdl/frot_pkg.sv
// Shared types, codes and size defaults of the quarter-turn frame rotator.
`timescale 1ns / 1ps
`default_nettype none
package frot_pkg;

	// Default frame store dimensions
	localparam int MAX_ROWS_DEF = 256;
	localparam int MAX_COLS_DEF = 256;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_TURNS = 2'd2;

	// Configuration field widths and reset values
	localparam int DIM_CFG_W   = 9;
	localparam int TURNS_W     = 2;
	localparam int CFG_DATA_W  = DIM_CFG_W;
	localparam logic [DIM_CFG_W-1:0] FRAME_ROWS_RST = 9'd256;
	localparam logic [DIM_CFG_W-1:0] FRAME_COLS_RST = 9'd256;
	localparam logic [TURNS_W-1:0]   TURNS_RST      = 2'd1;

	// Rotation codes
	localparam logic [TURNS_W-1:0] TURN_0 = 2'd0;
	localparam logic [TURNS_W-1:0] TURN_1 = 2'd1;
	localparam logic [TURNS_W-1:0] TURN_2 = 2'd2;
	localparam logic [TURNS_W-1:0] TURN_3 = 2'd3;

	// Command opcodes
	localparam logic OP_STORE = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam int PIX_W = 8;

	typedef struct packed {
		logic             opcode;
		logic [PIX_W-1:0] pixel_in;
	} frot_cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             last_pixel;
		logic             not_ready;
	} frot_result_t;

	// Flags that follow one fetch down the read pipeline
	typedef struct packed {
		logic valid;
		logic not_ready;
		logic last;
	} frot_rd_ctl_t;

endpackage
`default_nettype wire

// File: hdl/frot_seq.sv
// Command sequencer: configuration, store count, rotated scan position and source coordinates.
`timescale 1ns / 1ps
`default_nettype none
module frot_seq #(
	parameter int MAX_ROWS = frot_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = frot_pkg::MAX_COLS_DEF,
	localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS,
	localparam int DW    = $clog2(MAXD + 1),
	localparam int PW    = $clog2(MAXD),
	localparam int AW    = $clog2(MAX_ROWS * MAX_COLS),
	localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1)
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   accept,
	input  wire  frot_pkg::frot_cmd_t             cmd,
	input  wire                                   cfg_write,
	input  wire  [frot_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [frot_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                  wr_en,
	output logic [AW-1:0]                         wr_addr,
	output logic [frot_pkg::PIX_W-1:0]            wr_data,
	output frot_pkg::frot_rd_ctl_t                ctl_s1,
	output logic [PW-1:0]                         sr_s1,
	output logic [PW-1:0]                         sc_s1,
	output logic [DW-1:0]                         cols
);

	logic [frot_pkg::DIM_CFG_W-1:0] frame_rows_q;
	logic [frot_pkg::DIM_CFG_W-1:0] frame_cols_q;
	logic [frot_pkg::TURNS_W-1:0]   turns_q;
	logic [CNT_W-1:0]               stored_q;
	logic [PW-1:0]                  out_row_q;
	logic [PW-1:0]                  out_col_q;

	logic [DW-1:0]   rows;
	logic [DW-1:0]   orows;
	logic [DW-1:0]   ocols;
	logic [2*DW-1:0] total;
	logic            full;
	logic            last;
	logic            wrap_col;
	logic            cfg_rearm;
	logic            fetch_go;
	logic [DW-1:0]   sr_d;
	logic [DW-1:0]   sc_d;

	// Clamp the configured sizes into the store
	always_comb begin
		if (frame_rows_q == '0) begin
			rows = DW'(1);
		end else if (32'(frame_rows_q) > MAX_ROWS) begin
			rows = DW'(MAX_ROWS);
		end else begin
			rows = DW'(frame_rows_q);
		end
		if (frame_cols_q == '0) begin
			cols = DW'(1);
		end else if (32'(frame_cols_q) > MAX_COLS) begin
			cols = DW'(MAX_COLS);
		end else begin
			cols = DW'(frame_cols_q);
		end
		orows = turns_q[0] ? cols : rows;
		ocols = turns_q[0] ? rows : cols;
		total = (2*DW)'(rows) * (2*DW)'(cols);
		full  = 32'(stored_q) >= 32'(total);
	end

	// Scan position flags
	always_comb begin
		last      = (DW'(out_row_q) == orows - DW'(1)) && (DW'(out_col_q) == ocols - DW'(1));
		wrap_col  = (DW'(out_col_q) + DW'(1)) >= ocols;
		cfg_rearm = cfg_write && (cfg_index == frot_pkg::CFG_FRAME_ROWS ||
			cfg_index == frot_pkg::CFG_FRAME_COLS || cfg_index == frot_pkg::CFG_QUARTER_TURNS);
		fetch_go  = accept && (cmd.opcode == frot_pkg::OP_FETCH) && full;
	end

	// Map the rotated position back to source coordinates
	always_comb begin
		case (turns_q)
			frot_pkg::TURN_0: begin
				sr_d = DW'(out_row_q);
				sc_d = DW'(out_col_q);
			end
			frot_pkg::TURN_1: begin
				sr_d = rows - DW'(1) - DW'(out_col_q);
				sc_d = DW'(out_row_q);
			end
			frot_pkg::TURN_2: begin
				sr_d = rows - DW'(1) - DW'(out_row_q);
				sc_d = cols - DW'(1) - DW'(out_col_q);
			end
			default: begin
				sr_d = DW'(out_col_q);
				sc_d = cols - DW'(1) - DW'(out_row_q);
			end
		endcase
	end

	// Store port: write the next raster pixel while the frame is open
	always_comb begin
		wr_en   = accept && (cmd.opcode == frot_pkg::OP_STORE) && !full;
		wr_addr = stored_q[AW-1:0];
		wr_data = cmd.pixel_in;
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= frot_pkg::FRAME_ROWS_RST;
			frame_cols_q <= frot_pkg::FRAME_COLS_RST;
			turns_q      <= frot_pkg::TURNS_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				frot_pkg::CFG_FRAME_ROWS:    frame_rows_q <= cfg_data;
				frot_pkg::CFG_FRAME_COLS:    frame_cols_q <= cfg_data;
				frot_pkg::CFG_QUARTER_TURNS: turns_q <= cfg_data[frot_pkg::TURNS_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance store count and scan position; rearm on last pixel or a size or turn write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_rearm || (fetch_go && last)) begin
			stored_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else begin
			if (wr_en) begin
				stored_q <= stored_q + CNT_W'(1);
			end
			if (fetch_go) begin
				if (wrap_col) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + PW'(1);
				end else begin
					out_col_q <= out_col_q + PW'(1);
				end
			end
		end
	end

	// Launch fetches into the read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid     <= accept && (cmd.opcode == frot_pkg::OP_FETCH);
			ctl_s1.not_ready <= !full;
			ctl_s1.last      <= full && last;
		end
	end

	always_ff @(posedge clk) begin
		sr_s1 <= sr_d[PW-1:0];
		sc_s1 <= sc_d[PW-1:0];
	end

endmodule
`default_nettype wire

// File: hdl/frot_store.sv
// Frame store memory with the read stage of the fetch pipeline.
`timescale 1ns / 1ps
`default_nettype none
module frot_store #(
	parameter int MAX_ROWS = frot_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = frot_pkg::MAX_COLS_DEF,
	localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS,
	localparam int DW    = $clog2(MAXD + 1),
	localparam int PW    = $clog2(MAXD),
	localparam int AW    = $clog2(MAX_ROWS * MAX_COLS),
	localparam int DEPTH = MAX_ROWS * MAX_COLS
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          wr_en,
	input  wire  [AW-1:0]                wr_addr,
	input  wire  [frot_pkg::PIX_W-1:0]   wr_data,
	input  wire  frot_pkg::frot_rd_ctl_t ctl_s1,
	input  wire  [PW-1:0]                sr_s1,
	input  wire  [PW-1:0]                sc_s1,
	input  wire  [DW-1:0]                cols,
	output logic                         result_valid,
	output frot_pkg::frot_result_t       result
);

	logic [frot_pkg::PIX_W-1:0] mem [DEPTH];

	frot_pkg::frot_rd_ctl_t     ctl_s2;
	logic [frot_pkg::PIX_W-1:0] rd_data_s2;
	logic [2*DW-1:0]            addr_full;

	// Form the linear source address
	assign addr_full = (2*DW)'(sr_s1) * (2*DW)'(cols) + (2*DW)'(sc_s1);

	// Write stored pixels
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read the source pixel; a store at the same edge leaves the old pixel on the read
	always_ff @(posedge clk) begin
		rd_data_s2 <= mem[addr_full[AW-1:0]];
	end

	// Advance fetch flags alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Drive the result; an early fetch shows zero
	always_comb begin
		result_valid      = ctl_s2.valid;
		result.pixel_out  = ctl_s2.not_ready ? '0 : rd_data_s2;
		result.last_pixel = ctl_s2.last;
		result.not_ready  = ctl_s2.not_ready;
	end

endmodule
`default_nettype wire

// File: hdl/frame_rotate_quarter_turns_core.sv
// Top level of the quarter-turn frame rotator.
// Takes one command per clock: busy stays low, so a store or fetch is accepted at every edge with
// start high. A store writes the next raster pixel; a fetch returns the next pixel of the rotated
// frame on result with result_valid high for one cycle, once the fetch has passed the read pipeline
// (source coordinates registered, then the address multiply-add feeding the registered frame store
// read). Results come back in command order and cannot be held off. Configuration writes are taken
// at any cycle with cfg_valid high, are meant for an idle block; size/turn writes rearm the frame.
`timescale 1ns / 1ps
`default_nettype none
module frame_rotate_quarter_turns_core #(
	parameter int MAX_ROWS = frot_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = frot_pkg::MAX_COLS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire  frot_pkg::frot_cmd_t        cmd,
	output logic                             result_valid,
	output frot_pkg::frot_result_t           result,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [frot_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [frot_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int DW   = $clog2(MAXD + 1);
	localparam int PW   = $clog2(MAXD);
	localparam int AW   = $clog2(MAX_ROWS * MAX_COLS);

	logic                       accept;
	logic                       cfg_write;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [frot_pkg::PIX_W-1:0] wr_data;
	frot_pkg::frot_rd_ctl_t     ctl_s1;
	logic [PW-1:0]              sr_s1;
	logic [PW-1:0]              sc_s1;
	logic [DW-1:0]              cols;

	// Handshakes: every cycle can take a command or a register write
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign cfg_write = cfg_valid && cfg_ready;

	frot_seq #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.ctl_s1   (ctl_s1),
		.sr_s1    (sr_s1),
		.sc_s1    (sc_s1),
		.cols     (cols)
	);

	frot_store #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.ctl_s1      (ctl_s1),
		.sr_s1       (sr_s1),
		.sc_s1       (sc_s1),
		.cols        (cols),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule
`default_nettype wire

// File: hdl/frot_checker.sv
// Port-level checker of the quarter-turn frame rotator and its bind.
`timescale 1ns / 1ps
`default_nettype none
module frot_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         start,
	input wire                         busy,
	input wire frot_pkg::frot_cmd_t    cmd,
	input wire                         result_valid,
	input wire frot_pkg::frot_result_t result
);

	// Every transfer of a fetch yields a result once it has passed the read pipeline
	a_fetch_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.opcode == frot_pkg::OP_FETCH) |-> ##2 result_valid)
		else $error("fetch without result");

	// A store yields no result
	a_store_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.opcode == frot_pkg::OP_STORE) |-> ##2 !result_valid)
		else $error("result after store");

	// No result without a fetch behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(start && !busy, 2) && $past(cmd.opcode, 2) == frot_pkg::OP_FETCH))
		else $error("result without fetch");

	// An early fetch shows a zero pixel and never the last mark
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.not_ready) |-> (result.pixel_out == '0 && !result.last_pixel))
		else $error("not-ready result carries data");

endmodule

bind frame_rotate_quarter_turns_core frot_checker u_frot_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.cmd         (cmd),
	.result_valid(result_valid),
	.result      (result)
);
`default_nettype wire

// File: tb/sv/frame_rotate_quarter_turns_core_tb.sv
// Self-checking testbench for the quarter-turn frame rotator core.
`timescale 1ns / 1ps
module frame_rotate_quarter_turns_core_tb;
	import frot_pkg::*;

	localparam int DRAIN_CYC    = 6;
	localparam int QUIET_LIMIT  = 1000;
	localparam int RAND_ITEMS   = 900;
	localparam int MAX_PRINTED  = 40;
	localparam int MEM_DEPTH    = MAX_ROWS_DEF * MAX_COLS_DEF;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam frot_result_t NOT_READY_RES = '{8'h00, 1'b0, 1'b1};

	typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DATA_W-1:0]    data;
		frot_cmd_t                c;
		bit                       chk;
		frot_result_t             want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	frot_cmd_t             cmd = '0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	wire                   busy;
	wire                   result_valid;
	wire                   cfg_ready;
	frot_result_t          result;

	// Shadow copy of the rotator: registers, frame memory and read position
	bit [PIX_W-1:0]       pix_mem [0:MEM_DEPTH-1];
	int                   n_filled = 0;
	int                   rot_r = 0;
	int                   rot_c = 0;
	logic [DIM_CFG_W-1:0] cfg_rows = FRAME_ROWS_RST;
	logic [DIM_CFG_W-1:0] cfg_cols = FRAME_COLS_RST;
	logic [TURNS_W-1:0]   cfg_turns = TURNS_RST;

	frot_result_t rotated_pending [$];
	dir_row_t     dir_tab [$];
	int           err_cnt = 0;
	int           quiet_cyc = 0;
	int           idle_max = 4;

	frame_rotate_quarter_turns_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Zero acts as one, anything above the store size is clipped to it
	function automatic int eff_dim(input logic [DIM_CFG_W-1:0] v);
		if (v == 0)
			return 1;
		return (v > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(v);
	endfunction

	function automatic void restart_frame();
		n_filled = 0;
		rot_r = 0;
		rot_c = 0;
	endfunction

	function automatic void cfg_apply(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_FRAME_ROWS: cfg_rows = val;
			CFG_FRAME_COLS: cfg_cols = val;
			CFG_QUARTER_TURNS: cfg_turns = val[TURNS_W-1:0];
			default: return;
		endcase
		restart_frame();
	endfunction

	// Advance the shadow state by one command; returns 1 when a result is due
	function automatic bit rotate_step(input frot_cmd_t c, output frot_result_t r);
		int rows, cols, total, orows, ocols, sr, sc;
		bit fin;
		rows = eff_dim(cfg_rows);
		cols = eff_dim(cfg_cols);
		total = rows * cols;
		orows = cfg_turns[0] ? cols : rows;
		ocols = cfg_turns[0] ? rows : cols;
		r = '0;
		if (c.opcode == OP_STORE) begin
			if (n_filled < total) begin
				pix_mem[n_filled] = c.pixel_in;
				n_filled++;
			end
			return 1'b0;
		end
		if (n_filled < total) begin
			r.not_ready = 1'b1;
			return 1'b1;
		end
		case (cfg_turns)
			TURN_0: begin
				sr = rot_r;
				sc = rot_c;
			end
			TURN_1: begin
				sr = rows - 1 - rot_c;
				sc = rot_r;
			end
			TURN_2: begin
				sr = rows - 1 - rot_r;
				sc = cols - 1 - rot_c;
			end
			default: begin
				sr = rot_c;
				sc = cols - 1 - rot_r;
			end
		endcase
		fin = (rot_r == orows - 1) && (rot_c == ocols - 1);
		r.pixel_out = pix_mem[sr * cols + sc];
		r.last_pixel = fin;
		if (fin) begin
			restart_frame();
		end else if (rot_c + 1 >= ocols) begin
			rot_c = 0;
			rot_r++;
		end else begin
			rot_c++;
		end
		return 1'b1;
	endfunction

	task automatic flag(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINTED)
			$display("%0d ns: mismatch: %s", $time, msg);
	endtask

	// Drop start if it is still held from a back-to-back transfer
	task automatic release_cmd();
		if (start)
			start <= 1'b0;
	endtask

	// Hold off until every expected pixel is back, then let the pipeline drain
	task automatic settle(input int drain);
		release_cmd();
		do @(posedge clk); while (rotated_pending.size() > 0);
		repeat (drain) @(posedge clk);
	endtask

	task automatic issue(input frot_cmd_t c, input bit chk, input frot_result_t want);
		frot_result_t got;
		int gap;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		if (rotate_step(c, got))
			rotated_pending.push_back(chk ? want : got);
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		settle(DRAIN_CYC);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_apply(idx, val);
	endtask

	function automatic void put_cmd(input logic op, input logic [PIX_W-1:0] pix,
			input bit chk = 1'b0, input frot_result_t want = '0);
		dir_row_t r;
		r.kind = ROW_CMD;
		r.idx = '0;
		r.data = '0;
		r.c.opcode = op;
		r.c.pixel_in = pix;
		r.chk = chk;
		r.want = want;
		dir_tab.push_back(r);
	endfunction

	function automatic void put_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = val;
		r.c = '0;
		r.chk = 1'b0;
		r.want = '0;
		dir_tab.push_back(r);
	endfunction

	// Compare each result transfer with the oldest expected pixel
	always @(posedge clk) begin
		frot_result_t want;
		if (arst_n && result_valid) begin
			if (rotated_pending.size() == 0) begin
				flag($sformatf("result %0h with nothing expected", result));
			end else begin
				want = rotated_pending.pop_front();
				if (result.pixel_out !== want.pixel_out)
					flag($sformatf("pixel_out %0h, want %0h",
						result.pixel_out, want.pixel_out));
				if (result.last_pixel !== want.last_pixel)
					flag($sformatf("last_pixel %0b, want %0b",
						result.last_pixel, want.last_pixel));
				if (result.not_ready !== want.not_ready)
					flag($sformatf("not_ready %0b, want %0b",
						result.not_ready, want.not_ready));
			end
		end
	end

	// End the run when no transfer of any kind happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				quiet_cyc <= 0;
			else
				quiet_cyc <= quiet_cyc + 1;
			if (quiet_cyc >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		frot_cmd_t c;
		logic [CFG_DATA_W-1:0] rv, cv, tv, wide;
		int sent, frame_no, total, stop_at, k, shape;
		bit broke;

		// Reset frame is 256x256, so early fetches are refused
		put_cmd(OP_FETCH, 8'h00, 1'b1, NOT_READY_RES);
		put_cmd(OP_STORE, 8'hFF);
		put_cmd(OP_FETCH, 8'hFF, 1'b1, NOT_READY_RES);
		// Zero sizes act as a single pixel
		put_cfg(CFG_FRAME_ROWS, 9'd0);
		put_cfg(CFG_FRAME_COLS, 9'd0);
		put_cfg(CFG_QUARTER_TURNS, {7'd0, TURN_0});
		put_cmd(OP_FETCH, 8'h00, 1'b1, NOT_READY_RES);
		put_cmd(OP_STORE, 8'hA5);
		put_cmd(OP_FETCH, 8'h00, 1'b1, '{8'hA5, 1'b1, 1'b0});
		// Rearmed after the last pixel; a store on a full frame is dropped
		put_cmd(OP_STORE, 8'h5A);
		put_cmd(OP_STORE, 8'h00);
		put_cmd(OP_FETCH, 8'hFF, 1'b1, '{8'h5A, 1'b1, 1'b0});
		// 2x3 frame, one turn, junk in the upper turn bits, spare index mid-frame
		put_cfg(CFG_FRAME_ROWS, 9'd2);
		put_cfg(CFG_FRAME_COLS, 9'd3);
		put_cfg(CFG_QUARTER_TURNS, {7'h7F, TURN_1});
		put_cmd(OP_STORE, 8'h00);
		put_cmd(OP_STORE, 8'hFF);
		put_cmd(OP_STORE, 8'h01);
		put_cfg(CFG_SPARE, 9'h1FF);
		put_cmd(OP_STORE, 8'h80);
		put_cmd(OP_STORE, 8'h7F);
		put_cmd(OP_STORE, 8'h10);
		repeat (6) put_cmd(OP_FETCH, 8'h00);
		put_cmd(OP_FETCH, 8'h00, 1'b1, NOT_READY_RES);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			else
				issue(dir_tab[i].c, dir_tab[i].chk, dir_tab[i].want);
		end

		// Random frames: mostly complete store/fetch passes, some cut short, with noise
		sent = 0;
		frame_no = 0;
		broke = 1'b0;
		while (sent < RAND_ITEMS) begin
			if (frame_no < 2 || broke || $urandom_range(0, 2) != 0) begin
				shape = $urandom_range(0, 19);
				wide = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(257, 511))
					: CFG_DATA_W'($urandom_range(1, 256));
				tv = CFG_DATA_W'($urandom_range(0, 511));
				if (frame_no == 0) begin
					rv = 9'd256;
					cv = 9'd1;
					tv = {7'd0, TURN_3};
				end else if (frame_no == 1) begin
					rv = 9'd0;
					cv = 9'd511;
					tv = {7'd0, TURN_2};
				end else if (shape < 15) begin
					rv = CFG_DATA_W'($urandom_range(0, 6));
					cv = CFG_DATA_W'($urandom_range(0, 6));
				end else if (shape == 15) begin
					rv = wide;
					cv = CFG_DATA_W'($urandom_range(0, 2));
				end else if (shape == 16) begin
					rv = CFG_DATA_W'($urandom_range(0, 2));
					cv = wide;
				end else begin
					rv = CFG_DATA_W'($urandom_range(7, 20));
					cv = CFG_DATA_W'($urandom_range(7, 20));
				end
				if ($urandom_range(0, 4) == 0)
					write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 511)));
				write_reg(CFG_FRAME_ROWS, rv);
				write_reg(CFG_FRAME_COLS, cv);
				write_reg(CFG_QUARTER_TURNS, tv);
			end
			total = eff_dim(cfg_rows) * eff_dim(cfg_cols);
			broke = ($urandom_range(0, 9) == 0);
			stop_at = broke ? $urandom_range(0, 2 * total - 1) : 2 * total;
			idle_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			for (k = 0; k < stop_at; k++) begin
				// Early fetch while filling, or a dropped store while reading out
				if ($urandom_range(0, 11) == 0) begin
					c.opcode = (k < total) ? OP_FETCH : OP_STORE;
					c.pixel_in = PIX_W'($urandom_range(0, 255));
					issue(c, 1'b0, '0);
					if (k < total)
						sent++;
				end
				if ($urandom_range(0, 39) == 0)
					settle(0);
				c.opcode = (k < total) ? OP_STORE : OP_FETCH;
				c.pixel_in = PIX_W'($urandom_range(0, 255));
				issue(c, 1'b0, '0);
				sent++;
			end
			frame_no++;
		end

		settle(DRAIN_CYC);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
